@@ src/iirtdf2_pkg.sv @@
package iirtdf2_pkg;

  localparam int MAX_ORDER   = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int STATE_BITS  = SAMPLE_BITS + 16;
  localparam int COEF_FRAC   = COEF_BITS - 4;
  localparam int NUM_COEFS   = 2 * MAX_ORDER + 1;

  localparam int ORDER_W   = 4;
  localparam int SNAP_W    = 20;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 20;
  localparam int CMD_W     = 2;
  localparam int CIDX_W    = 5;

  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam int CNT_W  = $clog2(NUM_COEFS);
  localparam int ST_AW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int RND_W  = PROD_W + 1 - COEF_FRAC;
  localparam int ACC_W  = STATE_BITS + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILTER    = 2'd0,
    CMD_LOAD_COEF = 2'd1,
    CMD_FILL      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP  = 1'b1;

  typedef enum logic [2:0] {
    STEP_Y = 3'b001,
    STEP_B = 3'b010,
    STEP_A = 3'b100
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } fsm_t;

  typedef struct packed {
    logic             vld;
    step_t            step;
    logic [ST_AW-1:0] idx;
  } tag_t;

  // Round a Q.51 product to Q.23: add half an LSB, then floor.
  function automatic logic signed [RND_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] s;
    s = {p[PROD_W-1], p} + ((PROD_W+1)'(1) << (COEF_FRAC - 1));
    return s[PROD_W:COEF_FRAC];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:SAMPLE_BITS-1]) || !(|v[ACC_W-1:SAMPLE_BITS-1])) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:STATE_BITS-1]) || !(|v[ACC_W-1:STATE_BITS-1])) begin
      return v[STATE_BITS-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

@@ src/iir_transposed_df2_filter.sv @@
// IIR filter, transposed direct form II, order 1..8, a0 taken as one.
// Input channel (in_valid / in_stall) carries one item per handshake:
//   cmd 0 filters in_sample_in and gives one item on the output channel,
//   cmd 1 loads coefficient slot in_coef_index (b0..bN, then a1..aN),
//   cmd 2 fills every state element with in_fill_value; cmd 3 is dropped.
// Configuration (cfg_valid / cfg_ready, always ready) writes filter_order
// at index 0 (also clears the state) and snap_threshold at index 1; the user
// must write only while the block is idle, which the block does not enforce.
// A filter item keeps the input stalled from accept until its last state
// write lands and its result has moved out. With N the order in use, one
// shared multiplier walks b0, then b(j+1) and a(j+1) for each state element,
// fed from the coefficient and state memories at one read each per cycle.
// The result goes via y_r to the output register; load and fill do not stall.
// The output register holds its item while out_stall is high; a new item is
// still accepted, and the next filter result waits for the register to free.
// Reset (rst_n low, synchronous) zeroes state and coefficients, sets the
// order to 2 and the snap threshold to 0; no clearing pass is needed.
module iir_transposed_df2_filter (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [iirtdf2_pkg::CMD_W-1:0]               in_cmd,
  input  logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0]  in_sample_in,
  input  logic                                        in_block_end,
  input  logic [iirtdf2_pkg::CIDX_W-1:0]              in_coef_index,
  input  logic signed [iirtdf2_pkg::COEF_BITS-1:0]    in_coef_value,
  input  logic signed [iirtdf2_pkg::STATE_BITS-1:0]   in_fill_value,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0]  out_sample_out,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [iirtdf2_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [iirtdf2_pkg::CFG_DAT_W-1:0]           cfg_data
);

  // configuration
  logic [iirtdf2_pkg::ORDER_W-1:0] order_r;
  logic [iirtdf2_pkg::SNAP_W-1:0]  snap_r;
  logic                            cfg_wr;
  logic [iirtdf2_pkg::ORD_W-1:0]   n_eff;

  // control
  iirtdf2_pkg::fsm_t               fsm_r, fsm_nxt;
  logic [iirtdf2_pkg::CNT_W-1:0]   k_r, k_nxt;
  logic [iirtdf2_pkg::ORD_W-1:0]   n_r;
  logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] x_r;
  logic                            blk_r;
  logic                            in_acc;
  logic                            start;

  // memories
  logic signed [iirtdf2_pkg::COEF_BITS-1:0]  coef_mem [iirtdf2_pkg::NUM_COEFS];
  logic signed [iirtdf2_pkg::STATE_BITS-1:0] st_mem   [iirtdf2_pkg::MAX_ORDER];
  logic [iirtdf2_pkg::NUM_COEFS-1:0]         coef_vld_r;
  logic [iirtdf2_pkg::MAX_ORDER-1:0]         st_vld_r;
  logic signed [iirtdf2_pkg::STATE_BITS-1:0] st_dflt_r;
  logic                                      coef_we;

  // issue stage
  logic [iirtdf2_pkg::CNT_W-1:0]  k_half;
  logic [iirtdf2_pkg::CNT_W-1:0]  iss_slot;
  logic [iirtdf2_pkg::CNT_W-1:0]  iss_snext;
  logic [iirtdf2_pkg::ST_AW-1:0]  iss_saddr;
  logic                           iss_use;
  iirtdf2_pkg::tag_t              iss_tag;

  // read / multiply stage
  iirtdf2_pkg::tag_t                          tag1_r;
  logic signed [iirtdf2_pkg::COEF_BITS-1:0]   coef_rd_r;
  logic signed [iirtdf2_pkg::STATE_BITS-1:0]  st_rd_r;
  logic                                       c_vld_q_r, s_vld_q_r, s_use_q_r;
  logic signed [iirtdf2_pkg::COEF_BITS-1:0]   coef_q;
  logic signed [iirtdf2_pkg::STATE_BITS-1:0]  st_q;
  logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] mul_a;

  // accumulate / writeback stage
  iirtdf2_pkg::tag_t                          tag2_r;
  logic signed [iirtdf2_pkg::PROD_W-1:0]      prod_r;
  logic signed [iirtdf2_pkg::STATE_BITS-1:0]  st2_r;
  logic signed [iirtdf2_pkg::RND_W-1:0]       rnd;
  logic signed [iirtdf2_pkg::ACC_W-1:0]       rnd_x, st2_x, sum, diff;
  logic signed [iirtdf2_pkg::ACC_W-1:0]       acc_r;
  logic signed [iirtdf2_pkg::STATE_BITS-1:0]  sv, wv;
  logic [iirtdf2_pkg::STATE_BITS-1:0]         mag;
  logic                                       st_we;

  // result
  logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] y_r;
  logic                                       y_pend_r;
  logic                                       out_load;
  logic                                       out_valid_r;
  logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] out_data_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign in_stall  = (fsm_r != iirtdf2_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign start     = in_acc && (iirtdf2_pkg::cmd_t'(in_cmd) == iirtdf2_pkg::CMD_FILTER);
  assign coef_we   = in_acc && (iirtdf2_pkg::cmd_t'(in_cmd) == iirtdf2_pkg::CMD_LOAD_COEF)
                     && (int'(in_coef_index) < iirtdf2_pkg::NUM_COEFS);

  always_comb begin
    if (order_r == '0) begin
      n_eff = iirtdf2_pkg::ORD_W'(1);
    end else if (int'(order_r) > iirtdf2_pkg::MAX_ORDER) begin
      n_eff = iirtdf2_pkg::ORD_W'(iirtdf2_pkg::MAX_ORDER);
    end else begin
      n_eff = iirtdf2_pkg::ORD_W'(order_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= iirtdf2_pkg::ORDER_W'(2);
      snap_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        iirtdf2_pkg::CFG_ORDER: order_r <= cfg_data[iirtdf2_pkg::ORDER_W-1:0];
        iirtdf2_pkg::CFG_SNAP:  snap_r  <= cfg_data[iirtdf2_pkg::SNAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Step k walks b0, then b(j+1), a(j+1) for each state element j.
  assign k_half    = k_r >> 1;
  assign iss_snext = k_half + iirtdf2_pkg::CNT_W'(1);

  always_comb begin
    iss_tag.vld = (fsm_r == iirtdf2_pkg::ST_RUN);
    if (k_r == '0) begin
      iss_tag.step = iirtdf2_pkg::STEP_Y;
      iss_tag.idx  = '0;
      iss_slot     = '0;
      iss_saddr    = '0;
      iss_use      = 1'b1;
    end else if (k_r[0]) begin
      iss_tag.step = iirtdf2_pkg::STEP_B;
      iss_tag.idx  = k_half[iirtdf2_pkg::ST_AW-1:0];
      iss_slot     = iss_snext;
      iss_saddr    = iss_snext[iirtdf2_pkg::ST_AW-1:0];
      iss_use      = (iss_snext < iirtdf2_pkg::CNT_W'(n_r));
    end else begin
      iss_tag.step = iirtdf2_pkg::STEP_A;
      iss_tag.idx  = iirtdf2_pkg::ST_AW'(k_half - iirtdf2_pkg::CNT_W'(1));
      iss_slot     = iirtdf2_pkg::CNT_W'(n_r) + k_half;
      iss_saddr    = '0;
      iss_use      = 1'b0;
    end
  end

  always_comb begin
    fsm_nxt = fsm_r;
    k_nxt   = k_r;
    unique case (fsm_r)
      iirtdf2_pkg::ST_IDLE: begin
        if (start) begin
          fsm_nxt = iirtdf2_pkg::ST_RUN;
          k_nxt   = '0;
        end
      end
      iirtdf2_pkg::ST_RUN: begin
        if (k_r == (iirtdf2_pkg::CNT_W'(n_r) << 1)) begin
          fsm_nxt = iirtdf2_pkg::ST_DRAIN;
        end else begin
          k_nxt = k_r + iirtdf2_pkg::CNT_W'(1);
        end
      end
      iirtdf2_pkg::ST_DRAIN: begin
        // hold until the last write lands and the result has moved out
        if (!tag1_r.vld && !tag2_r.vld && !y_pend_r) begin
          fsm_nxt = iirtdf2_pkg::ST_IDLE;
        end
      end
      default: fsm_nxt = iirtdf2_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= iirtdf2_pkg::ST_IDLE;
      k_r   <= '0;
    end else begin
      fsm_r <= fsm_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= in_sample_in;
      blk_r <= in_block_end;
      n_r   <= n_eff;
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[in_coef_index] <= in_coef_value;
    end
    coef_rd_r <= coef_mem[iss_slot];
  end

  // state memory
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[tag2_r.idx] <= wv;
    end
    st_rd_r <= st_mem[iss_saddr];
  end

  // Entries without a valid bit read as the reset or fill value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      st_vld_r   <= '0;
      st_dflt_r  <= '0;
    end else begin
      if (coef_we) begin
        coef_vld_r[in_coef_index] <= 1'b1;
      end
      if (cfg_wr && (cfg_index == iirtdf2_pkg::CFG_ORDER)) begin
        st_vld_r  <= '0;
        st_dflt_r <= '0;
      end else if (in_acc && (iirtdf2_pkg::cmd_t'(in_cmd) == iirtdf2_pkg::CMD_FILL)) begin
        st_vld_r  <= '0;
        st_dflt_r <= in_fill_value;
      end else if (st_we) begin
        st_vld_r[tag2_r.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    c_vld_q_r <= coef_vld_r[iss_slot];
    s_vld_q_r <= st_vld_r[iss_saddr];
    s_use_q_r <= iss_use;
  end

  assign coef_q = c_vld_q_r ? coef_rd_r : '0;
  assign st_q   = !s_use_q_r ? '0 : (s_vld_q_r ? st_rd_r : st_dflt_r);
  assign mul_a  = (tag1_r.step == iirtdf2_pkg::STEP_A) ? y_r : x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= iss_tag;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * coef_q;
    st2_r  <= st_q;
  end

  assign rnd   = iirtdf2_pkg::rnd_prod(prod_r);
  assign rnd_x = {{(iirtdf2_pkg::ACC_W-iirtdf2_pkg::RND_W){rnd[iirtdf2_pkg::RND_W-1]}}, rnd};
  assign st2_x = {{(iirtdf2_pkg::ACC_W-iirtdf2_pkg::STATE_BITS){st2_r[iirtdf2_pkg::STATE_BITS-1]}},
                  st2_r};
  assign sum   = rnd_x + st2_x;
  assign diff  = acc_r - rnd_x;
  assign sv    = iirtdf2_pkg::sat_state(diff);
  assign mag   = sv[iirtdf2_pkg::STATE_BITS-1] ? (~sv + iirtdf2_pkg::STATE_BITS'(1)) : sv;
  // snap small state values to zero at block end
  assign wv    = (blk_r && (mag <= iirtdf2_pkg::STATE_BITS'(snap_r))) ? '0 : sv;
  assign st_we = tag2_r.vld && (tag2_r.step == iirtdf2_pkg::STEP_A);

  always_ff @(posedge clk) begin
    if (tag2_r.vld && (tag2_r.step == iirtdf2_pkg::STEP_B)) begin
      acc_r <= sum;
    end
    if (tag2_r.vld && (tag2_r.step == iirtdf2_pkg::STEP_Y)) begin
      y_r <= iirtdf2_pkg::sat_sample(sum);
    end
  end

  assign out_load = y_pend_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_pend_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (tag2_r.vld && (tag2_r.step == iirtdf2_pkg::STEP_Y)) begin
        y_pend_r <= 1'b1;
      end else if (out_load) begin
        y_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= y_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule
